/* design/dmwc_pkg.sv */
// Shared types, codes and helpers for the direct-mapped word cache.
// No dependencies; used by dmwc_seq and direct_mapped_word_cache.
package dmwc_pkg;

  localparam int INDEX_BITS_DEFAULT = 10;

  localparam int CFG_W = 3;
  localparam logic [CFG_W-1:0] REFILL_LOG2_RESET = 3'd2;
  localparam logic [CFG_W-1:0] REFILL_LOG2_MIN   = 3'd2;
  localparam logic [CFG_W-1:0] REFILL_LOG2_MAX   = 3'd5;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_FILL   = 1'b1;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic        hit;
    logic [31:0] read_data;
    logic [31:0] fetch_address;
    logic [1:0]  fetch_mode;
    logic        last;
  } beat_t;

  // Zero-extended little-endian lane by byte offset; size three reads as a word.
  function automatic logic [31:0] lane_select(input logic [31:0] word,
                                              input logic [1:0]  boff,
                                              input logic [1:0]  size);
    logic [31:0] res;
    res = word;
    case (size)
      SIZE_HALF: begin
        res = boff[1] ? {16'b0, word[31:16]} : {16'b0, word[15:0]};
      end
      SIZE_BYTE: begin
        case (boff)
          2'd0:    res = {24'b0, word[7:0]};
          2'd1:    res = {24'b0, word[15:8]};
          2'd2:    res = {24'b0, word[23:16]};
          default: res = {24'b0, word[31:24]};
        endcase
      end
      default: res = word;
    endcase
    return res;
  endfunction

endpackage

/* design/direct_mapped_word_cache.sv */
// Top level of the direct-mapped word cache: line RAM, sequencer and the
// output beat register. Depends on dmwc_pkg, dmwc_line_ram, dmwc_seq.
//
//  channel   direction  handshake                payload
//  in        in         in_valid / in_stall      func address access_size isolated
//                                                access_mode fill_data fill_error
//  out       out        out_valid / out_stall    kind hit read_data fetch_address
//                                                fetch_mode last
//  cfg       in         cfg_write_en             cfg_write_data (refill_size_log2)
//
// A lookup is accepted in S_READY, which reads the line RAM; a hit or isolated miss
// registers its answer from S_LOOK. A miss moves on to S_FETCH, which issues 4 to 32
// fetch requests, one per cycle while the output is not stalled. A fill word is
// written in S_READY; after the block's final fill word the line is reread in S_FRD
// and answered in S_FANS. The single line RAM and its registered read set these steps.
// After reset a clearing pass writes all 2**INDEX_BITS lines, one per cycle,
// with in_stall high. A stalled output holds the sequencer in its result state.
module direct_mapped_word_cache #(
  parameter int INDEX_BITS = dmwc_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [31:0]                address,
  input  logic [1:0]                 access_size,
  input  logic                       isolated,
  input  logic [1:0]                 access_mode,
  input  logic [31:0]                fill_data,
  input  logic                       fill_error,
  input  logic                       cfg_write_en,
  input  logic [dmwc_pkg::CFG_W-1:0] cfg_write_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       kind,
  output logic                       hit,
  output logic [31:0]                read_data,
  output logic [31:0]                fetch_address,
  output logic [1:0]                 fetch_mode,
  output logic                       last
);

  localparam int TAG_W   = 30 - INDEX_BITS;
  localparam int ENTRY_W = 1 + TAG_W + 32;

  dmwc_pkg::beat_t       beat;
  dmwc_pkg::beat_t       out_beat;
  logic                  out_free;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [INDEX_BITS-1:0] ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  assign out_free = !out_valid || !out_stall;

  dmwc_line_ram #(
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dmwc_seq #(
    .INDEX_BITS (INDEX_BITS),
    .TAG_W      (TAG_W),
    .ENTRY_W    (ENTRY_W)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .address        (address),
    .access_size    (access_size),
    .isolated       (isolated),
    .access_mode    (access_mode),
    .fill_data      (fill_data),
    .fill_error     (fill_error),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_free       (out_free),
    .beat           (beat),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= beat.valid;
    end
  end

  // Load a new beat only when the register is empty or being drained.
  always_ff @(posedge clk) begin
    if (out_free && beat.valid) begin
      out_beat <= beat;
    end
  end

  assign kind          = out_beat.kind;
  assign hit           = out_beat.hit;
  assign read_data     = out_beat.read_data;
  assign fetch_address = out_beat.fetch_address;
  assign fetch_mode    = out_beat.fetch_mode;
  assign last          = out_beat.last;

endmodule

/* design/dmwc_line_ram.sv */
// Line store: one synchronous RAM, one write and one read port, registered read.
// No package dependencies.
module dmwc_line_ram #(
  parameter int INDEX_BITS = 10,
  parameter int ENTRY_W    = 53
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [INDEX_BITS-1:0] waddr,
  input  logic [ENTRY_W-1:0]    wdata,
  input  logic                  re,
  input  logic [INDEX_BITS-1:0] raddr,
  output logic [ENTRY_W-1:0]    rdata
);

  logic [ENTRY_W-1:0] mem [2**INDEX_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/dmwc_seq.sv */
// Lookup / refill sequencer: drives the line RAM, tracks the pending refill
// and produces result beats. Depends on dmwc_pkg.
module dmwc_seq #(
  parameter int INDEX_BITS = dmwc_pkg::INDEX_BITS_DEFAULT,
  parameter int TAG_W      = 30 - INDEX_BITS,
  parameter int ENTRY_W    = 1 + TAG_W + 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [31:0]                  address,
  input  logic [1:0]                   access_size,
  input  logic                         isolated,
  input  logic [1:0]                   access_mode,
  input  logic [31:0]                  fill_data,
  input  logic                         fill_error,
  input  logic                         cfg_write_en,
  input  logic [dmwc_pkg::CFG_W-1:0]   cfg_write_data,
  input  logic                         out_free,
  output dmwc_pkg::beat_t              beat,
  output logic                         ram_we,
  output logic [INDEX_BITS-1:0]        ram_waddr,
  output logic [ENTRY_W-1:0]           ram_wdata,
  output logic                         ram_re,
  output logic [INDEX_BITS-1:0]        ram_raddr,
  input  logic [ENTRY_W-1:0]           ram_rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_READY = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FANS  = 3'd5;

  logic [2:0]                  state, state_next;
  logic [dmwc_pkg::CFG_W-1:0]  refill_size_log2;
  logic                        pending, pending_next;
  logic [31:0]                 pend_addr, pend_addr_next;
  logic [1:0]                  pend_size, pend_size_next;
  logic [5:0]                  fill_count, fill_count_next;
  logic [4:0]                  fetch_k, fetch_k_next;
  logic [INDEX_BITS-1:0]       clr_idx, clr_idx_next;

  logic [31:0] req_addr;
  logic [1:0]  req_size;
  logic        req_iso;
  logic [1:0]  req_mode;

  logic [dmwc_pkg::CFG_W-1:0] blk_lg;
  logic [5:0]  words;
  logic [31:0] blk_mask;
  logic [31:0] fill_addr;
  logic [31:0] fetch_addr;
  logic [5:0]  fill_count_inc;
  logic [5:0]  fetch_k_inc;
  logic        rd_valid;
  logic [TAG_W-1:0] rd_tag;
  logic [31:0] rd_data;
  logic        lk_hit;

  always_comb begin
    if (refill_size_log2 < dmwc_pkg::REFILL_LOG2_MIN) begin
      blk_lg = dmwc_pkg::REFILL_LOG2_MIN;
    end else if (refill_size_log2 > dmwc_pkg::REFILL_LOG2_MAX) begin
      blk_lg = dmwc_pkg::REFILL_LOG2_MAX;
    end else begin
      blk_lg = refill_size_log2;
    end
  end

  assign words          = 6'd1 << blk_lg;
  assign blk_mask       = ~((32'd4 << blk_lg) - 32'd1);
  assign fill_addr      = (pend_addr & blk_mask) + {24'b0, fill_count, 2'b00};
  assign fetch_addr     = (pend_addr & blk_mask) + {25'b0, fetch_k, 2'b00};
  assign fill_count_inc = fill_count + 6'd1;
  assign fetch_k_inc    = {1'b0, fetch_k} + 6'd1;

  assign rd_valid = ram_rdata[ENTRY_W-1];
  assign rd_tag   = ram_rdata[32 +: TAG_W];
  assign rd_data  = ram_rdata[31:0];
  assign lk_hit   = rd_valid && (rd_tag == req_addr[31:INDEX_BITS+2]);

  assign in_stall = (state != S_READY);

  always_comb begin
    state_next      = state;
    pending_next    = pending;
    pend_addr_next  = pend_addr;
    pend_size_next  = pend_size;
    fill_count_next = fill_count;
    fetch_k_next    = fetch_k;
    clr_idx_next    = clr_idx;
    ram_we          = 1'b0;
    ram_waddr       = clr_idx;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = address[INDEX_BITS+1:2];
    beat            = '0;
    case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        clr_idx_next = clr_idx + 1'b1;
        if (&clr_idx) begin
          state_next = S_READY;
        end
      end
      S_READY: begin
        if (in_valid) begin
          if (func == dmwc_pkg::FUNC_LOOKUP) begin
            // A lookup abandons any pending refill.
            ram_re          = 1'b1;
            pending_next    = 1'b0;
            fill_count_next = 6'd0;
            state_next      = S_LOOK;
          end else if (pending) begin
            ram_we    = !fill_error;
            ram_waddr = fill_addr[INDEX_BITS+1:2];
            ram_wdata = {1'b1, fill_addr[31:INDEX_BITS+2], fill_data};
            if (fill_count_inc >= words) begin
              pending_next    = 1'b0;
              fill_count_next = 6'd0;
              state_next      = S_FRD;
            end else begin
              fill_count_next = fill_count_inc;
            end
          end
        end
      end
      S_LOOK: begin
        if (lk_hit || req_iso) begin
          beat.valid     = 1'b1;
          beat.kind      = dmwc_pkg::KIND_READ;
          beat.hit       = lk_hit;
          beat.read_data = dmwc_pkg::lane_select(rd_data, req_addr[1:0], req_size);
          beat.last      = 1'b1;
          if (out_free) begin
            state_next = S_READY;
          end
        end else begin
          pending_next   = 1'b1;
          pend_addr_next = req_addr;
          pend_size_next = req_size;
          fetch_k_next   = 5'd0;
          state_next     = S_FETCH;
        end
      end
      S_FETCH: begin
        beat.valid         = 1'b1;
        beat.kind          = dmwc_pkg::KIND_FETCH;
        beat.fetch_address = fetch_addr;
        beat.fetch_mode    = req_mode;
        beat.last          = (fetch_k_inc == words);
        if (out_free) begin
          if (beat.last) begin
            state_next = S_READY;
          end else begin
            fetch_k_next = fetch_k_inc[4:0];
          end
        end
      end
      S_FRD: begin
        // Read after the last fill write has landed.
        ram_re     = 1'b1;
        ram_raddr  = pend_addr[INDEX_BITS+1:2];
        state_next = S_FANS;
      end
      S_FANS: begin
        beat.valid     = 1'b1;
        beat.kind      = dmwc_pkg::KIND_READ;
        beat.hit       = 1'b0;
        beat.read_data = dmwc_pkg::lane_select(rd_data, pend_addr[1:0], pend_size);
        beat.last      = 1'b1;
        if (out_free) begin
          state_next = S_READY;
        end
      end
      default: begin
        state_next = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      refill_size_log2 <= dmwc_pkg::REFILL_LOG2_RESET;
      pending          <= 1'b0;
      pend_addr        <= 32'd0;
      pend_size        <= 2'd0;
      fill_count       <= 6'd0;
      fetch_k          <= 5'd0;
      clr_idx          <= '0;
    end else begin
      state      <= state_next;
      pending    <= pending_next;
      pend_addr  <= pend_addr_next;
      pend_size  <= pend_size_next;
      fill_count <= fill_count_next;
      fetch_k    <= fetch_k_next;
      clr_idx    <= clr_idx_next;
      if (cfg_write_en) begin
        refill_size_log2 <= cfg_write_data;
      end
    end
  end

  // Capture the lookup request.
  always_ff @(posedge clk) begin
    if (state == S_READY && in_valid && func == dmwc_pkg::FUNC_LOOKUP) begin
      req_addr <= address;
      req_size <= access_size;
      req_iso  <= isolated;
      req_mode <= access_mode;
    end
  end

  a_fill_count_bound: assert property (@(posedge clk) disable iff (rst)
    pending |-> (fill_count < 6'd32))
    else $error("fill count beyond largest refill block");

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!beat.valid && !ram_re))
    else $error("beat or read during clearing pass");

  a_fetch_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (beat.valid && out_free && beat.kind == dmwc_pkg::KIND_FETCH && beat.last)
      |=> pending)
    else $error("refill not pending after last fetch request");

  a_no_write_on_read_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK || state == S_FANS) |-> !ram_we)
    else $error("line write while read data in use");

endmodule
